>>> rtl/core/bgbd_pkg.sv
// ----------------------------------------------------------------------------
// bgbd_pkg
// shared constants, codes and types of the grbg bilinear demosaic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgbd_pkg;

	// line store depth and the widths that follow from it
	localparam int MAX_LINE_WIDTH = 2048;
	localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);

	localparam int PIX_W      = 8;
	localparam int CFG_W_W    = 12;
	localparam int CFG_H_W    = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int IROW_W     = CFG_H_W + 1;
	localparam int OROW_W     = CFG_H_W;

	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	// window taps, [row][column], row 0 is the upper line
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	// per item control travelling down the pipe
	typedef struct packed {
		logic               valid;
		logic               emit;
		logic               draining;
		logic [PIX_W-1:0]   sample;
		logic [LINE_AW-1:0] addr;
		logic               has_left;
		logic               has_right;
		logic               has_up;
		logic               has_down;
		logic               row_odd;
		logic               col_odd;
		logic               line_end;
		logic               frame_end;
	} pix_meta_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             line_end;
		logic             frame_end;
	} rgb_word_t;

endpackage

>>> rtl/core/bgbd_stream_if.sv
// ----------------------------------------------------------------------------
// bgbd stream interfaces
// raw sample channel and rgb pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bgbd_raw_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [bgbd_pkg::PIX_W-1:0] raw_value;

	modport source (output valid, cmd, raw_value, input ready);
	modport sink   (input valid, cmd, raw_value, output ready);
endinterface

interface bgbd_rgb_if;
	logic                      valid;
	logic                      ready;
	logic [bgbd_pkg::PIX_W-1:0] red;
	logic [bgbd_pkg::PIX_W-1:0] green;
	logic [bgbd_pkg::PIX_W-1:0] blue;
	logic                      line_end;
	logic                      frame_end;

	modport source (output valid, red, green, blue, line_end, frame_end, input ready);
	modport sink   (input valid, red, green, blue, line_end, frame_end, output ready);
endinterface

>>> rtl/core/bgbd_ram.sv
// ----------------------------------------------------------------------------
// bgbd_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/bgbd_ctrl.sv
// ----------------------------------------------------------------------------
// bgbd_ctrl
// raster counters, emission and edge flags, first pipeline stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgbd_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic                           in_cmd,
	input  logic [bgbd_pkg::PIX_W-1:0]     in_raw,
	input  logic [bgbd_pkg::CFG_W_W-1:0]   eff_w,
	input  logic [bgbd_pkg::CFG_H_W-1:0]   eff_h,
	output logic [bgbd_pkg::LINE_AW-1:0]   rd_col,
	output bgbd_pkg::pix_meta_t            meta_s1
);

	logic [bgbd_pkg::LINE_AW-1:0] icol_q, icol_n, ocol_q, ocol_n;
	logic [bgbd_pkg::IROW_W-1:0]  irow_q, irow_n;
	logic [bgbd_pkg::OROW_W-1:0]  orow_q, orow_n;
	logic                         draining, ignore, take, emit, col_wrap, le, fe;
	bgbd_pkg::pix_meta_t          meta;

	always_comb begin
		draining = 32'(irow_q) >= 32'(eff_h);
		ignore   = (in_cmd == bgbd_pkg::CMD_FLUSH) && !draining;
		take     = en && in_valid && !ignore;
		emit     = draining || (irow_q >= bgbd_pkg::IROW_W'(2))
		           || ((irow_q == bgbd_pkg::IROW_W'(1)) && (icol_q != '0));

		col_wrap = (32'(icol_q) + 32'd1) >= 32'(eff_w);
		le       = (32'(ocol_q) + 32'd1) >= 32'(eff_w);
		fe       = le && ((32'(orow_q) + 32'd1) >= 32'(eff_h));

		// input raster position
		if (col_wrap) begin
			icol_n = '0;
			irow_n = bgbd_pkg::IROW_W'(32'(irow_q) + 32'd1);
		end else begin
			icol_n = bgbd_pkg::LINE_AW'(32'(icol_q) + 32'd1);
			irow_n = irow_q;
		end
		if (32'(irow_n) > (32'(eff_h) + 32'd1)) begin
			irow_n = bgbd_pkg::IROW_W'(32'(eff_h) + 32'd1);
		end

		// output raster position
		ocol_n = ocol_q;
		orow_n = orow_q;
		if (emit) begin
			if (le) begin
				ocol_n = '0;
				orow_n = bgbd_pkg::OROW_W'(32'(orow_q) + 32'd1);
			end else begin
				ocol_n = bgbd_pkg::LINE_AW'(32'(ocol_q) + 32'd1);
			end
			if (fe) begin
				icol_n = '0;
				irow_n = '0;
				ocol_n = '0;
				orow_n = '0;
			end
		end

		meta.valid     = take;
		meta.emit      = emit;
		meta.draining  = draining;
		meta.sample    = draining ? '0 : in_raw;
		meta.addr      = icol_q;
		meta.has_left  = ocol_q != '0;
		meta.has_right = (32'(ocol_q) + 32'd1) < 32'(eff_w);
		meta.has_up    = orow_q != '0;
		meta.has_down  = (32'(orow_q) + 32'd1) < 32'(eff_h);
		meta.row_odd   = orow_q[0];
		meta.col_odd   = ocol_q[0];
		meta.line_end  = le;
		meta.frame_end = fe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q  <= '0;
			irow_q  <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1 <= meta;
			if (take) begin
				icol_q <= icol_n;
				irow_q <= irow_n;
				ocol_q <= ocol_n;
				orow_q <= orow_n;
			end
		end
	end

	assign rd_col = icol_q;

	// a stalled stage one keeps its line store address for the re-read
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		meta_s1.valid && !en |=> meta_s1.valid && $stable(meta_s1.addr))
		else $error("stage one lost its item during a stall");

endmodule

>>> rtl/core/bgbd_window.sv
// ----------------------------------------------------------------------------
// bgbd_window
// line store ram read-modify-write and the 3x3 window taps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgbd_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [bgbd_pkg::LINE_AW-1:0] rd_col,
	input  bgbd_pkg::pix_meta_t          meta_s1,
	output bgbd_pkg::window_t            win,
	output bgbd_pkg::pix_meta_t          meta_s2
);

	localparam int LS_W = 2 * bgbd_pkg::PIX_W;

	logic [bgbd_pkg::LINE_AW-1:0] raddr;
	logic [LS_W-1:0]              rdata, wdata;
	logic [bgbd_pkg::PIX_W-1:0]   up_v, mid_v;
	logic                         we, shift;
	bgbd_pkg::window_t            win_q;

	// upper line in the high byte, middle line in the low byte
	assign up_v  = rdata[LS_W-1:bgbd_pkg::PIX_W];
	assign mid_v = rdata[bgbd_pkg::PIX_W-1:0];

	// while stalled, keep re-reading the entry of the waiting item
	assign raddr = en ? rd_col : meta_s1.addr;
	assign shift = en && meta_s1.valid;
	assign we    = shift && !meta_s1.draining;
	assign wdata = {mid_v, meta_s1.sample};

	bgbd_ram #(
		.WIDTH (LS_W),
		.DEPTH (bgbd_pkg::MAX_LINE_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (we),
		.waddr (meta_s1.addr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			meta_s2 <= '0;
		end else if (en) begin
			meta_s2 <= meta_s1;
			if (shift) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= up_v;
				win_q[1][2] <= mid_v;
				win_q[2][2] <= meta_s1.sample;
			end
		end
	end

	assign win = win_q;

endmodule

>>> rtl/core/bgbd_interp.sv
// ----------------------------------------------------------------------------
// bgbd_interp
// neighbour averages per bayer site, output register with skid stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgbd_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  bgbd_pkg::window_t   win,
	input  bgbd_pkg::pix_meta_t meta_s2,
	input  logic                out_ready,
	output logic                en,
	output logic                out_valid,
	output bgbd_pkg::rgb_word_t out_word
);

	localparam int SUM_W = bgbd_pkg::PIX_W + 2;
	localparam int RECIP_SH = 11;
	localparam int PROD_W = SUM_W + RECIP_SH;
	localparam logic [RECIP_SH-1:0] RECIP3 = 11'd683;

	typedef enum logic [1:0] {
		SITE_GR = 2'b00,
		SITE_R  = 2'b01,
		SITE_B  = 2'b10,
		SITE_GB = 2'b11
	} site_t;

	// average over one to four neighbours, thirds by reciprocal
	function automatic logic [bgbd_pkg::PIX_W-1:0] avg_of(input logic [SUM_W-1:0] sum,
	                                                      input logic [2:0] n);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(sum) * PROD_W'(RECIP3);
		case (n)
			3'd1:    avg_of = sum[bgbd_pkg::PIX_W-1:0];
			3'd2:    avg_of = sum[bgbd_pkg::PIX_W:1];
			3'd3:    avg_of = prod[RECIP_SH +: bgbd_pkg::PIX_W];
			3'd4:    avg_of = sum[bgbd_pkg::PIX_W+1:2];
			default: avg_of = '0;
		endcase
	endfunction

	logic [SUM_W-1:0]    hs, vs, ds, gs;
	logic [2:0]          hn, vn, dn, gn;
	logic                hl, hr, hu, hd, push;
	site_t               site;
	bgbd_pkg::rgb_word_t res;
	bgbd_pkg::rgb_word_t out_word_q, skid_word_q;
	logic                out_valid_q, skid_valid_q;

	always_comb begin
		hl = meta_s2.has_left;
		hr = meta_s2.has_right;
		hu = meta_s2.has_up;
		hd = meta_s2.has_down;

		hs = (hl ? SUM_W'(win[1][0]) : '0) + (hr ? SUM_W'(win[1][2]) : '0);
		hn = 3'(hl) + 3'(hr);
		vs = (hu ? SUM_W'(win[0][1]) : '0) + (hd ? SUM_W'(win[2][1]) : '0);
		vn = 3'(hu) + 3'(hd);
		ds = ((hu && hl) ? SUM_W'(win[0][0]) : '0) + ((hu && hr) ? SUM_W'(win[0][2]) : '0)
		   + ((hd && hl) ? SUM_W'(win[2][0]) : '0) + ((hd && hr) ? SUM_W'(win[2][2]) : '0);
		dn = 3'(hu && hl) + 3'(hu && hr) + 3'(hd && hl) + 3'(hd && hr);
		gs = hs + vs;
		gn = hn + vn;

		site = site_t'({meta_s2.row_odd, meta_s2.col_odd});
		case (site)
			SITE_GR: begin
				res.green = win[1][1];
				res.red   = avg_of(hs, hn);
				res.blue  = avg_of(vs, vn);
			end
			SITE_R: begin
				res.red   = win[1][1];
				res.green = avg_of(gs, gn);
				res.blue  = avg_of(ds, dn);
			end
			SITE_B: begin
				res.blue  = win[1][1];
				res.green = avg_of(gs, gn);
				res.red   = avg_of(ds, dn);
			end
			SITE_GB: begin
				res.green = win[1][1];
				res.red   = avg_of(vs, vn);
				res.blue  = avg_of(hs, hn);
			end
			default: begin
				res.green = win[1][1];
				res.red   = '0;
				res.blue  = '0;
			end
		endcase
		res.line_end  = meta_s2.line_end;
		res.frame_end = meta_s2.frame_end;
	end

	// pipe moves whenever the skid slot is free
	assign en   = !skid_valid_q;
	assign push = en && meta_s2.valid && meta_s2.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_word_q <= skid_word_q;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_word_q <= res;
			end else begin
				out_word_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid filled without a stalled output");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && !push && !skid_valid_q |=> !out_valid_q)
		else $error("taken word shown again");

endmodule

>>> rtl/core/bayer_grbg_bilinear_demosaic_top.sv
// ----------------------------------------------------------------------------
// bayer_grbg_bilinear_demosaic_top
// streaming bilinear demosaic of a grbg bayer mosaic to rgb pixels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// channel    dir  word                                    accepted when
// pix_in     in   cmd, raw_value                          valid && ready
// pix_out    out  red, green, blue, line_end, frame_end   valid && ready
// cfg        in   cfg_index, cfg_wdata                    cfg_wr_en high
//
// one word per clock sustained while the skid stage is free; the line store ram
// does one read and one write per cycle, a pixel goes through the stage one,
// window and output registers after the word that completes it is taken
// reset clears counters, window taps and the output stage, line stores are not
// cleared and need no sweep, so words are taken from the first cycle on
// a stalled output fills a one-word skid stage, ready drops only when it is full
// a flush word before the last row is taken and dropped

module bayer_grbg_bilinear_demosaic_top (
	input  logic                              clk,
	input  logic                              arst_n,
	bgbd_raw_if.sink                          pix_in,
	bgbd_rgb_if.source                        pix_out,
	input  logic                              cfg_wr_en,
	input  logic [bgbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bgbd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic [bgbd_pkg::CFG_W_W-1:0]  width_q, eff_w;
	logic [bgbd_pkg::CFG_H_W-1:0]  height_q, eff_h;
	logic                          en;
	logic [bgbd_pkg::LINE_AW-1:0]  rd_col;
	bgbd_pkg::pix_meta_t           meta_s1, meta_s2;
	bgbd_pkg::window_t             win;
	bgbd_pkg::rgb_word_t           out_word;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bgbd_pkg::WIDTH_RESET;
			height_q <= bgbd_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (bgbd_pkg::cfg_index_t'(cfg_index))
				bgbd_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata[bgbd_pkg::CFG_W_W-1:0];
				bgbd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata[bgbd_pkg::CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to what the line stores and the edge logic can handle
	always_comb begin
		eff_w = width_q;
		if (width_q < bgbd_pkg::CFG_W_W'(2)) begin
			eff_w = bgbd_pkg::CFG_W_W'(2);
		end else if (32'(width_q) > bgbd_pkg::MAX_LINE_WIDTH) begin
			eff_w = bgbd_pkg::CFG_W_W'(bgbd_pkg::MAX_LINE_WIDTH);
		end
		eff_h = (height_q < bgbd_pkg::CFG_H_W'(2)) ? bgbd_pkg::CFG_H_W'(2) : height_q;
	end

	// raster counters and emission decision, stage one
	bgbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pix_in.valid),
		.in_cmd   (pix_in.cmd),
		.in_raw   (pix_in.raw_value),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.rd_col   (rd_col),
		.meta_s1  (meta_s1)
	);

	// line stores and window, stage two
	bgbd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rd_col  (rd_col),
		.meta_s1 (meta_s1),
		.win     (win),
		.meta_s2 (meta_s2)
	);

	// interpolation and output staging
	bgbd_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win),
		.meta_s2   (meta_s2),
		.out_ready (pix_out.ready),
		.en        (en),
		.out_valid (pix_out.valid),
		.out_word  (out_word)
	);

	// ready is the registered skid state, never a path from the output side
	assign pix_in.ready      = en;
	assign pix_out.red       = out_word.red;
	assign pix_out.green     = out_word.green;
	assign pix_out.blue      = out_word.blue;
	assign pix_out.line_end  = out_word.line_end;
	assign pix_out.frame_end = out_word.frame_end;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// grbg bilinear demosaic: every raw word taken by the block goes through a
// cycle-free software copy of the line stores, window and raster counters;
// every rgb word that leaves is compared field by field, in order, with the
// oldest predicted pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_PERIOD       = 8;
	localparam int RESET_CYCLES     = 6;
	localparam int SETTLE_CYCLES    = 16;   // long enough for the pipe to empty
	localparam int LONG_HOLD_CYCLES = 600;  // output hold-off, long enough to fill the pipe
	localparam int STALL_LIMIT      = 4000; // cycles with no word moving on either side
	localparam int RANDOM_WORDS     = 650;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	bgbd_pkg::cfg_index_t            cfg_index;
	logic [bgbd_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bgbd_raw_if raw_ch ();
	bgbd_rgb_if rgb_ch ();

	bayer_grbg_bilinear_demosaic_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (raw_ch.sink),
		.pix_out   (rgb_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ------------------------------------------------------------------------
	// predictor state: our own copy of the stores, taps, counters and registers
	// ------------------------------------------------------------------------
	logic [bgbd_pkg::PIX_W-1:0]   upper_store  [bgbd_pkg::MAX_LINE_WIDTH];
	logic [bgbd_pkg::PIX_W-1:0]   middle_store [bgbd_pkg::MAX_LINE_WIDTH];
	bgbd_pkg::window_t            taps;
	int unsigned                  in_col, in_row, out_col, out_row;
	logic [bgbd_pkg::CFG_W_W-1:0] width_reg;
	logic [bgbd_pkg::CFG_H_W-1:0] height_reg;

	// pixels predicted but not yet seen on the output, oldest first
	bgbd_pkg::rgb_word_t expected_pixels [$];

	// sender and receiver control shared with the test tasks
	bit          offering;      // mirror of the valid we last drove
	int unsigned burst_left;
	bit          gapless;       // no gaps between bursts while set
	bit          long_hold_req; // asks the receiver for one long hold-off
	int unsigned mismatches;
	int unsigned words_taken;   // words that did something in the block
	int unsigned pixels_seen;
	int unsigned stall_cycles;

	// clock: inverted every half period
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// effective geometry, registers clamped the way the block reads them
	// ------------------------------------------------------------------------
	function automatic int unsigned eff_width();
		if (width_reg < 2)
			return 2;
		if (width_reg > bgbd_pkg::MAX_LINE_WIDTH)
			return bgbd_pkg::MAX_LINE_WIDTH;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 2) ? 2 : 32'(height_reg);
	endfunction

	// truncating average, empty set gives zero
	function automatic logic [bgbd_pkg::PIX_W-1:0] mean(input int unsigned sum,
			input int unsigned n);
		return (n == 0) ? '0 : bgbd_pkg::PIX_W'(sum / n);
	endfunction

	task automatic reset_prediction();
		int i;
		for (i = 0; i < bgbd_pkg::MAX_LINE_WIDTH; i++) begin
			upper_store[i]  = '0;
			middle_store[i] = '0;
		end
		taps       = '0;
		in_col     = 0;
		in_row     = 0;
		out_col    = 0;
		out_row    = 0;
		width_reg  = bgbd_pkg::WIDTH_RESET;
		height_reg = bgbd_pkg::HEIGHT_RESET;
	endtask

	// ------------------------------------------------------------------------
	// predictor: one taken word in, zero or one pixel onto expected_pixels
	// ------------------------------------------------------------------------
	task automatic demosaic_predict(input bgbd_pkg::cmd_t cmd,
			input logic [bgbd_pkg::PIX_W-1:0] raw);
		int unsigned w, h, ic, ir, r, c, hs, hn, vs, vn, ds, dn, i;
		logic [bgbd_pkg::PIX_W-1:0] smp, up_v, mid_v, ctr;
		bit draining, emit, hu, hd, hl, hr;
		bgbd_pkg::rgb_word_t px;

		w = eff_width();
		h = eff_height();
		draining = (in_row >= h);

		// a flush before the last row has arrived is dropped without trace
		if (cmd == bgbd_pkg::CMD_FLUSH && !draining)
			return;
		words_taken++;

		// while draining every word is a flush tick, its sample thrown away
		smp = draining ? '0 : raw;
		ic  = in_col;
		ir  = in_row;

		up_v  = upper_store[ic];
		mid_v = middle_store[ic];
		if (!draining) begin
			upper_store[ic]  = mid_v;
			middle_store[ic] = smp;
		end

		for (i = 0; i < 3; i++) begin
			taps[i][0] = taps[i][1];
			taps[i][1] = taps[i][2];
		end
		taps[0][2] = up_v;
		taps[1][2] = mid_v;
		taps[2][2] = smp;

		// output runs one line and one pixel behind the input
		emit = draining || ir >= 2 || (ir == 1 && ic >= 1);

		if (ic + 1 >= w) begin
			in_col = 0;
			in_row = ir + 1;
		end else begin
			in_col = ic + 1;
		end
		if (in_row > h + 1)
			in_row = h + 1;

		if (!emit)
			return;

		r  = out_row;
		c  = out_col;
		hu = (r > 0);
		hd = (r + 1 < h);
		hl = (c > 0);
		hr = (c + 1 < w);
		ctr = taps[1][1];
		hs = 0; hn = 0; vs = 0; vn = 0; ds = 0; dn = 0;

		// neighbours off the image are left out of sum and divisor alike
		if (hl) begin hs += taps[1][0]; hn++; end
		if (hr) begin hs += taps[1][2]; hn++; end
		if (hu) begin vs += taps[0][1]; vn++; end
		if (hd) begin vs += taps[2][1]; vn++; end
		if (hu && hl) begin ds += taps[0][0]; dn++; end
		if (hu && hr) begin ds += taps[0][2]; dn++; end
		if (hd && hl) begin ds += taps[2][0]; dn++; end
		if (hd && hr) begin ds += taps[2][2]; dn++; end

		case ({r[0], c[0]})
			2'b00: begin // green on a red row
				px.green = ctr;
				px.red   = mean(hs, hn);
				px.blue  = mean(vs, vn);
			end
			2'b01: begin // red site
				px.red   = ctr;
				px.green = mean(hs + vs, hn + vn);
				px.blue  = mean(ds, dn);
			end
			2'b10: begin // blue site
				px.blue  = ctr;
				px.green = mean(hs + vs, hn + vn);
				px.red   = mean(ds, dn);
			end
			default: begin // green on a blue row
				px.green = ctr;
				px.red   = mean(vs, vn);
				px.blue  = mean(hs, hn);
			end
		endcase

		px.line_end  = (c + 1 >= w);
		px.frame_end = px.line_end && (r + 1 >= h);
		expected_pixels.push_back(px);

		if (px.line_end) begin
			out_col = 0;
			out_row = r + 1;
		end else begin
			out_col = c + 1;
		end
		// last pixel of the frame rewinds all four counters
		if (px.frame_end) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		end
	endtask

	// ------------------------------------------------------------------------
	// sender: bursts of random length, random gaps between them
	// ------------------------------------------------------------------------
	task automatic send_word(input bgbd_pkg::cmd_t cmd, input logic [bgbd_pkg::PIX_W-1:0] raw);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = gapless ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				if (offering)
					raw_ch.valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		raw_ch.valid     <= 1'b1;
		raw_ch.cmd       <= cmd;
		raw_ch.raw_value <= raw;
		offering = 1'b1;
		// ready is read as it stood at the edge
		do @(posedge clk); while (!raw_ch.ready);
		demosaic_predict(cmd, raw);
	endtask

	// stop offering and let every predicted pixel come out, then let the pipe
	// settle in case a word that yields nothing is still inside
	task automatic wait_idle();
		if (offering)
			raw_ch.valid <= 1'b0;
		offering   = 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only ever happen with the block idle
	task automatic set_geometry(input logic [bgbd_pkg::CFG_DATA_W-1:0] w_raw,
			input logic [bgbd_pkg::CFG_DATA_W-1:0] h_raw);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= bgbd_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata <= w_raw;
		@(posedge clk);
		width_reg = w_raw[bgbd_pkg::CFG_W_W-1:0];
		cfg_index <= bgbd_pkg::CFG_IMAGE_HEIGHT;
		cfg_wdata <= h_raw;
		@(posedge clk);
		height_reg = h_raw[bgbd_pkg::CFG_H_W-1:0];
		cfg_wr_en <= 1'b0;
	endtask

	// one whole frame at the current geometry, then its drain ticks;
	// noise adds early flushes, raw words among the ticks and a stray flush
	// after the frame; pause_at > 0 waits for all results at that sample
	task automatic send_frame(input int unsigned pat, input bit noisy,
			input int unsigned pause_at);
		int unsigned n_px, n_ticks, i;
		logic [bgbd_pkg::PIX_W-1:0] v;
		n_px    = eff_width() * eff_height();
		n_ticks = eff_width() + 1;
		for (i = 0; i < n_px; i++) begin
			case (pat)
				0:       v = bgbd_pkg::PIX_W'($urandom_range(0, 255));
				1:       v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: v = $urandom_range(0, 1) ? bgbd_pkg::PIX_W'($urandom_range(252, 255))
				                                  : bgbd_pkg::PIX_W'($urandom_range(0, 3));
			endcase
			if (pause_at != 0 && i == pause_at)
				wait_idle();
			if (noisy && $urandom_range(0, 31) == 0)
				send_word(bgbd_pkg::CMD_FLUSH, bgbd_pkg::PIX_W'($urandom_range(0, 255)));
			send_word(bgbd_pkg::CMD_PIXEL, v);
		end
		for (i = 0; i < n_ticks; i++) begin
			if (noisy && $urandom_range(0, 3) == 0)
				send_word(bgbd_pkg::CMD_PIXEL, bgbd_pkg::PIX_W'($urandom_range(0, 255)));
			else
				send_word(bgbd_pkg::CMD_FLUSH, bgbd_pkg::PIX_W'($urandom_range(0, 255)));
		end
		if (noisy && $urandom_range(0, 1) == 1)
			send_word(bgbd_pkg::CMD_FLUSH, bgbd_pkg::PIX_W'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// smallest frames, register clamping, early flush, raw word while draining
	task automatic test_directed_edges();
		int unsigned i;
		// 0 and 1 both read as 2
		set_geometry(13'd0, 13'd1);
		send_word(bgbd_pkg::CMD_FLUSH, 8'hA5); // before any row, dropped
		send_word(bgbd_pkg::CMD_PIXEL, 8'hFF);
		send_word(bgbd_pkg::CMD_PIXEL, 8'h00);
		send_word(bgbd_pkg::CMD_FLUSH, 8'h5A); // last row not in yet, dropped
		send_word(bgbd_pkg::CMD_PIXEL, 8'h00);
		send_word(bgbd_pkg::CMD_PIXEL, 8'hFF);
		send_word(bgbd_pkg::CMD_FLUSH, 8'h00);
		send_word(bgbd_pkg::CMD_PIXEL, 8'h7E); // draining, counts as a tick
		send_word(bgbd_pkg::CMD_FLUSH, 8'hFF);
		send_word(bgbd_pkg::CMD_FLUSH, 8'h81); // after frame end, early again

		// 3x3: every site kind, the centre with a full neighbourhood, the rest partial
		set_geometry(13'd3, 13'd3);
		for (i = 0; i < 9; i++)
			send_word(bgbd_pkg::CMD_PIXEL,
				(i == 8) ? 8'h01 : ((i % 2 == 0) ? 8'hFF : 8'h00));
		for (i = 0; i < 4; i++)
			send_word(bgbd_pkg::CMD_FLUSH, 8'h00);
	endtask

	// output held off long enough to fill the block and stall its input, then
	// the sender pauses mid-frame until every result is out
	task automatic test_backpressure();
		set_geometry(13'd16, 13'd6);
		gapless       = 1'b1;
		long_hold_req = 1'b1;
		send_frame(0, 1'b0, 48);
		gapless = 1'b0;
	endtask

	// many small frames with random geometry, content and noise
	task automatic test_random_frames();
		int unsigned w, h, start;
		logic [bgbd_pkg::CFG_DATA_W-1:0] w_raw, h_raw;
		bit first;
		first = 1'b1;
		start = words_taken;
		while (words_taken - start < RANDOM_WORDS) begin
			if (first || $urandom_range(0, 2) != 0) begin
				w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
				h = $urandom_range(2, 8);
				w_raw = (w == 2) ? bgbd_pkg::CFG_DATA_W'($urandom_range(0, 2))
				                 : bgbd_pkg::CFG_DATA_W'(w);
				h_raw = (h == 2) ? bgbd_pkg::CFG_DATA_W'($urandom_range(0, 2))
				                 : bgbd_pkg::CFG_DATA_W'(h);
				// top data bit set once, the width register ignores it
				if (first)
					w_raw = w_raw | 13'h1000;
				first = 1'b0;
				set_geometry(w_raw, h_raw);
			end
			gapless = ($urandom_range(0, 3) == 0);
			send_frame($urandom_range(0, 2), 1'($urandom_range(0, 1)), 0);
		end
		gapless = 1'b0;
	endtask

	// a wide line, reaching far into the line stores
	task automatic test_line_store_depth();
		set_geometry(13'd200, 13'd2);
		send_frame(0, 1'b1, 0);
	endtask

	// a tall frame on the narrowest line
	task automatic test_tall_frame();
		set_geometry(13'd1, 13'd100);
		send_frame(2, 1'b1, 0);
	endtask

	// ------------------------------------------------------------------------
	// receiver: ready pattern changes after each span of random length, with whole
	// stretches of no stall, and one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : rx_pattern
		int unsigned span, pct;
		rgb_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			span = $urandom_range(32, 256);
			case ($urandom_range(0, 3))
				0:       pct = 100;
				1:       pct = 70;
				2:       pct = 30;
				default: pct = 90;
			endcase
			repeat (span) begin
				if (long_hold_req) begin
					long_hold_req = 1'b0;
					rgb_ch.ready <= 1'b0;
					repeat (LONG_HOLD_CYCLES) @(posedge clk);
				end
				rgb_ch.ready <= ($urandom_range(1, 100) <= pct);
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// result check: each rgb word against the oldest predicted pixel
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: pixel %0d %s expected %0d actual %0d",
				$time, pixels_seen, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : pixel_check
		bgbd_pkg::rgb_word_t want;
		if (arst_n && rgb_ch.valid && rgb_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$display("%0t ns: pixel %0d expected none actual r%0d g%0d b%0d",
					$time, pixels_seen, rgb_ch.red, rgb_ch.green, rgb_ch.blue);
			end else begin
				want = expected_pixels.pop_front();
				check_field("red",       want.red,       rgb_ch.red);
				check_field("green",     want.green,     rgb_ch.green);
				check_field("blue",      want.blue,      rgb_ch.blue);
				check_field("line_end",  want.line_end,  rgb_ch.line_end);
				check_field("frame_end", want.frame_end, rgb_ch.frame_end);
			end
			pixels_seen++;
		end
	end

	// watchdog: nothing moving on either channel for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (raw_ch.valid && raw_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, stall_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n           <= 1'b0;
		raw_ch.valid     <= 1'b0;
		raw_ch.cmd       <= bgbd_pkg::CMD_PIXEL;
		raw_ch.raw_value <= '0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= bgbd_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata        <= '0;
		offering      = 1'b0;
		burst_left    = 0;
		gapless       = 1'b0;
		long_hold_req = 1'b0;
		mismatches    = 0;
		words_taken   = 0;
		pixels_seen   = 0;
		reset_prediction();

		// single reset at the start of the run
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_backpressure();
		test_random_frames();
		test_line_store_depth();
		test_tall_frame();

		// all words in, wait for the last pixels and a quiet tail
		wait_idle();
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/bgbd_pkg.sv
rtl/core/bgbd_stream_if.sv
rtl/core/bgbd_ram.sv
rtl/core/bgbd_ctrl.sv
rtl/core/bgbd_window.sv
rtl/core/bgbd_interp.sv
rtl/core/bayer_grbg_bilinear_demosaic_top.sv
dv/testbench.sv
